@@ hw/rtl/svsd_pkg.sv @@
package svsd_pkg;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  localparam int DigitCells = 3;

  // range limits on the raw reading
  localparam logic signed [31:0] BIG_POS_MIN   = 32'sd99990;
  localparam logic signed [31:0] SCALE_POS_MIN = 32'sd10000;
  localparam logic signed [31:0] KEEP_MIN      = -32'sd999;
  localparam logic signed [31:0] SCALE_NEG_MIN = -32'sd9989;

  localparam logic [16:0] CLAMP_POS_MAG = 17'd9999;
  localparam logic [16:0] CLAMP_NEG_MAG = 17'd999;

  // reciprocals of ten in 16 fractional bits
  localparam logic [12:0] RECIP_SCALE = 13'd6553;
  localparam logic [12:0] RECIP_DIGIT = 13'd6554;

  typedef struct packed {
    logic               channel;
    logic signed [31:0] reading;
  } item_t;

  typedef struct packed {
    logic       group;
    logic [7:0] seg_digit0;
    logic [7:0] seg_digit1;
    logic [7:0] seg_digit2;
    logic [7:0] seg_digit3;
  } result_t;

  typedef struct packed {
    logic        group;
    logic        neg;
    logic        point;
    logic        scale;
    logic [16:0] mag;
  } range_t;

  typedef struct packed {
    logic            group;
    logic            neg;
    logic            point;
    logic [13:0]     rest;
    logic [2:0][3:0] digits;
  } digit_pipe_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] code;
    unique case (d)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/signed_value_to_seven_segment.sv @@
// signed reading (tenths) to four seven-segment bytes for one of two groups
//
// item channel: item_valid / item_ready / item (channel, reading)
// result channel: result_valid / result_ready / result (group, seg_digit0..3,
//   seg_digit0 leftmost, bits 0-6 segments a-g, bit 7 decimal point)
//
// six register stages: range select and abs, divide-by-ten for scaled
// values, three digit cells that each peel off one decimal digit, and the
// segment formatter whose register drives the result port
// throughput: one transaction per cycle while result_ready is high,
// set by one register per cell
// each stage holds its own valid bit and is ready when empty or draining, so
// a waiting result does not block new items while upstream stages have room
// a stalled receiver fills the chain; after six held items item_ready drops
// synchronous reset clears all valid bits; payload registers are not reset
module signed_value_to_seven_segment (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  svsd_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output svsd_pkg::result_t  result
);
  import svsd_pkg::*;

  range_t      range_stage;
  logic        range_valid;
  logic        range_ready;

  digit_pipe_t pipe_stage [DigitCells+1];
  logic        pipe_valid [DigitCells+1];
  logic        pipe_ready [DigitCells+1];

  svsd_range u_range (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .out_valid (range_valid),
    .out_ready (range_ready),
    .out_stage (range_stage)
  );

  svsd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (range_valid),
    .in_ready  (range_ready),
    .in_stage  (range_stage),
    .out_valid (pipe_valid[0]),
    .out_ready (pipe_ready[0]),
    .out_stage (pipe_stage[0])
  );

  for (genvar i = 0; i < DigitCells; i++) begin : g_cell
    svsd_digit_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[i]),
      .in_ready  (pipe_ready[i]),
      .in_stage  (pipe_stage[i]),
      .out_valid (pipe_valid[i+1]),
      .out_ready (pipe_ready[i+1]),
      .out_stage (pipe_stage[i+1])
    );
  end

  svsd_format u_format (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pipe_valid[DigitCells]),
    .in_ready   (pipe_ready[DigitCells]),
    .in_stage   (pipe_stage[DigitCells]),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_result (result)
  );

endmodule

@@ hw/rtl/svsd_range.sv @@
module svsd_range (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  svsd_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output svsd_pkg::range_t  out_stage
);
  import svsd_pkg::*;

  range_t      stage_next;
  logic [31:0] neg_reading;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    neg_reading      = 32'd0 - 32'(in_item.reading);
    stage_next       = '0;
    stage_next.group = in_item.channel;
    if (in_item.reading >= BIG_POS_MIN) begin
      stage_next.mag = CLAMP_POS_MAG;
    end else if (in_item.reading >= SCALE_POS_MIN) begin
      stage_next.scale = 1'b1;
      stage_next.mag   = in_item.reading[16:0];
    end else if (in_item.reading >= KEEP_MIN) begin
      stage_next.point = 1'b1;
      stage_next.neg   = in_item.reading[31];
      stage_next.mag   = in_item.reading[31] ? neg_reading[16:0] : in_item.reading[16:0];
    end else if (in_item.reading >= SCALE_NEG_MIN) begin
      stage_next.scale = 1'b1;
      stage_next.neg   = 1'b1;
      stage_next.mag   = neg_reading[16:0];
    end else begin
      stage_next.neg = 1'b1;
      stage_next.mag = CLAMP_NEG_MAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stage.point |->
      !out_stage.scale && out_stage.mag <= (out_stage.neg ? 17'd999 : 17'd9999))
    else $error("kept value outside the one-decimal range");
`endif

endmodule

@@ hw/rtl/svsd_scale.sv @@
module svsd_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svsd_pkg::range_t       in_stage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svsd_pkg::digit_pipe_t  out_stage
);
  import svsd_pkg::*;

  digit_pipe_t stage_next;
  logic [29:0] prod;
  logic [13:0] quot;
  logic [16:0] rem;

  assign in_ready = !out_valid || out_ready;

  // estimate is low by at most one, fixed by one compare and increment
  always_comb begin
    prod = 30'(in_stage.mag) * 30'(RECIP_SCALE);
    quot = prod[29:16];
    rem  = in_stage.mag - ({3'd0, quot} << 3) - ({3'd0, quot} << 1);
    stage_next        = '0;
    stage_next.group  = in_stage.group;
    stage_next.neg    = in_stage.neg;
    stage_next.point  = in_stage.point;
    if (in_stage.scale) begin
      stage_next.rest = (rem >= 17'd10) ? quot + 14'd1 : quot;
    end else begin
      stage_next.rest = in_stage.mag[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_stage.rest <= 14'd9999)
    else $error("magnitude exceeds four digits");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stage.neg |-> out_stage.rest <= 14'd999)
    else $error("negative magnitude exceeds three digits");
`endif

endmodule

@@ hw/rtl/svsd_digit_cell.sv @@
module svsd_digit_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svsd_pkg::digit_pipe_t  in_stage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svsd_pkg::digit_pipe_t  out_stage
);
  import svsd_pkg::*;

  digit_pipe_t stage_next;
  logic [26:0] prod;
  logic [13:0] quot;
  logic [13:0] rem;

  assign in_ready = !out_valid || out_ready;

  // exact for rest up to 9999
  always_comb begin
    prod = 27'(in_stage.rest) * 27'(RECIP_DIGIT);
    quot = {3'd0, prod[26:16]};
    rem  = in_stage.rest - (quot << 3) - (quot << 1);
    stage_next        = in_stage;
    stage_next.rest   = quot;
    // new digit enters at the top, older ones shift down
    stage_next.digits = {rem[3:0], in_stage.digits[2:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_stage.digits[2] <= 4'd9)
    else $error("extracted digit out of range");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_stage.rest <= 14'd999)
    else $error("quotient did not shrink");
`endif

endmodule

@@ hw/rtl/svsd_format.sv @@
module svsd_format (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svsd_pkg::digit_pipe_t  in_stage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svsd_pkg::result_t      out_result
);
  import svsd_pkg::*;

  result_t    result_next;
  logic [3:0] d0;
  logic [3:0] d1;
  logic [3:0] d2;
  logic [3:0] d3;
  logic       has_d1;
  logic       has_d2;
  logic       has_d3;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    d0     = in_stage.digits[0];
    d1     = in_stage.digits[1];
    d2     = in_stage.digits[2];
    d3     = in_stage.rest[3:0];
    has_d3 = d3 != 4'd0;
    has_d2 = has_d3 || d2 != 4'd0;
    has_d1 = has_d2 || d1 != 4'd0;
    result_next       = '0;
    result_next.group = in_stage.group;
    result_next.seg_digit3 = seg_code(d0);
    if (!has_d1) begin
      // below ten tenths: leading zero with point
      result_next.seg_digit1 = in_stage.neg ? SEG_DASH : SEG_BLANK;
      result_next.seg_digit2 = seg_code(4'd0) | SEG_POINT;
    end else begin
      result_next.seg_digit2 = seg_code(d1) | (in_stage.point ? SEG_POINT : SEG_BLANK);
      if (has_d2) begin
        result_next.seg_digit1 = seg_code(d2);
      end else begin
        result_next.seg_digit1 = in_stage.neg ? SEG_DASH : SEG_BLANK;
      end
      if (has_d3) begin
        result_next.seg_digit0 = seg_code(d3);
      end else begin
        result_next.seg_digit0 = (has_d2 && in_stage.neg) ? SEG_DASH : SEG_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= result_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.seg_digit3 != SEG_BLANK && !out_result.seg_digit3[7])
    else $error("rightmost position lacks a digit");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_result.seg_digit0[7] && !out_result.seg_digit1[7])
    else $error("point lit on a leading position");
`endif

endmodule
